// ===== rtl/core/lbcs_pkg.sv =====
// Shared constants for the LED blink-code sequencer.
package lbcs_pkg;

  // Step codes of the frame sequencer
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_BLUE_ON   = 3'd0;
  localparam logic [STEP_W-1:0] ST_BLUE_OFF  = 3'd1;
  localparam logic [STEP_W-1:0] ST_GAP       = 3'd2;
  localparam logic [STEP_W-1:0] ST_GREEN_ON  = 3'd3;
  localparam logic [STEP_W-1:0] ST_GREEN_OFF = 3'd4;
  localparam logic [STEP_W-1:0] ST_PAUSE     = 3'd5;

  // Phase codes on the result channel
  localparam int unsigned PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_BLUE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_GAP   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GREEN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS    = 3'd5;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned MS_W  = 16;

  localparam logic [MS_W-1:0] ON_MS_RST    = 16'd100;
  localparam logic [MS_W-1:0] OFF_MS_RST   = 16'd500;
  localparam logic [MS_W-1:0] GAP_MS_RST   = 16'd800;
  localparam logic [MS_W-1:0] PAUSE_MS_RST = 16'd1500;

  localparam int unsigned TIME_WIDTH_DEF = 16;

endpackage

// ===== rtl/core/led_blink_code_sequencer.sv =====
// LED blink-code sequencer: millisecond-tick driven blue/green blink frames.
//
// Usage:
//   Input channel (in_valid / in_stall / in_tick): one transfer per item.
//   in_tick = 1 advances the frame timer by one millisecond, 0 holds time.
//   Result channel (out_valid / out_stall / out_blue_lit, out_green_lit,
//   out_phase): exactly one result per input transfer, giving the LED state
//   and phase reached after that item.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no result is outstanding. Unknown indexes ignored.
// Output: the result is registered at the input transfer. Throughput: one
//   item per cycle while in_stall is low; the whole step (empty-run skip,
//   timer increment, duration compare, step advance) is one pass of logic
//   between the sequencer state and the output register.
// Stall: while the output register holds an untaken result and out_stall is
//   high, in_stall is raised; once out_stall drops, input flows every cycle.
// Reset (rst_n low, synchronous): counts 0, durations 100/500/800/1500 ms,
//   sequencer at blue-on with timer and blink index cleared, no result held.
module led_blink_code_sequencer
  import lbcs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_tick,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_blue_lit,
  output logic                  out_green_lit,
  output logic [PHASE_W-1:0]    out_phase,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Wide enough to compare a 16-bit duration against the timer limit
  localparam int unsigned DUR_W = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

  typedef struct packed {
    logic [STEP_W-1:0]     step;
    logic [CNT_W-1:0]      blink;
    logic [TIME_WIDTH-1:0] tcnt;
  } seq_t;

  // Config registers
  logic [CNT_W-1:0] blue_count_r, green_count_r;
  logic [MS_W-1:0]  on_ms_r, off_ms_r, gap_ms_r, pause_ms_r;

  // Sequencer state and result register
  seq_t              seq_r, seq_nxt;
  logic              out_valid_r;
  logic              blue_lit_r, green_lit_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;

  logic in_xfer;
  logic cfg_xfer;

  // Zero counts as 1 ms; saturate to what the timer can reach
  function automatic logic [TIME_WIDTH-1:0] sat_dur(input logic [MS_W-1:0] d);
    logic [DUR_W-1:0] ext;
    logic [DUR_W-1:0] lim;
    ext = DUR_W'(d);
    lim = DUR_W'({TIME_WIDTH{1'b1}});
    if (ext > lim) ext = lim;
    if (ext == '0) ext = DUR_W'(1);
    return ext[TIME_WIDTH-1:0];
  endfunction

  // Leave a blink run at once when its count is already reached
  function automatic seq_t skip_empty(input seq_t s, input logic [CNT_W-1:0] bc,
                                      input logic [CNT_W-1:0] gc);
    seq_t r;
    r = s;
    if (r.step == ST_BLUE_ON && r.blink >= bc) begin
      r.step  = ST_GAP;
      r.blink = '0;
      r.tcnt  = '0;
    end
    if (r.step == ST_GREEN_ON && r.blink >= gc) begin
      r.step  = ST_PAUSE;
      r.blink = '0;
      r.tcnt  = '0;
    end
    return r;
  endfunction

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // One item: skip; on a tick also tick, compare, advance, skip again
  always_comb begin
    seq_t              s;
    logic [TIME_WIDTH-1:0] dur;
    logic [CNT_W:0]    nxt_idx;
    s = skip_empty(seq_r, blue_count_r, green_count_r);
    if (in_tick) begin
      if (s.tcnt != {TIME_WIDTH{1'b1}}) s.tcnt = s.tcnt + 1'b1;
      case (s.step)
        ST_BLUE_ON, ST_GREEN_ON:   dur = sat_dur(on_ms_r);
        ST_BLUE_OFF, ST_GREEN_OFF: dur = sat_dur(off_ms_r);
        ST_GAP:                    dur = sat_dur(gap_ms_r);
        default:                   dur = sat_dur(pause_ms_r);
      endcase
      nxt_idx = {1'b0, s.blink} + 1'b1;
      if (s.tcnt >= dur) begin
        s.tcnt = '0;
        case (s.step)
          ST_BLUE_ON:  s.step = ST_BLUE_OFF;
          ST_BLUE_OFF: begin
            if (nxt_idx < {1'b0, blue_count_r}) begin
              s.step  = ST_BLUE_ON;
              s.blink = nxt_idx[CNT_W-1:0];
            end else begin
              s.step  = ST_GAP;
              s.blink = '0;
            end
          end
          ST_GAP: begin
            s.step  = ST_GREEN_ON;
            s.blink = '0;
          end
          ST_GREEN_ON: s.step = ST_GREEN_OFF;
          ST_GREEN_OFF: begin
            if (nxt_idx < {1'b0, green_count_r}) begin
              s.step  = ST_GREEN_ON;
              s.blink = nxt_idx[CNT_W-1:0];
            end else begin
              s.step  = ST_PAUSE;
              s.blink = '0;
            end
          end
          default: begin
            s.step  = ST_BLUE_ON;
            s.blink = '0;
          end
        endcase
      end
      s = skip_empty(s, blue_count_r, green_count_r);
    end else begin
      dur     = '0;
      nxt_idx = '0;
    end
    seq_nxt = s;

    case (s.step)
      ST_BLUE_ON, ST_BLUE_OFF:   phase_nxt = PH_BLUE;
      ST_GAP:                    phase_nxt = PH_GAP;
      ST_GREEN_ON, ST_GREEN_OFF: phase_nxt = PH_GREEN;
      default:                   phase_nxt = PH_PAUSE;
    endcase
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_count_r  <= '0;
      green_count_r <= '0;
      on_ms_r       <= ON_MS_RST;
      off_ms_r      <= OFF_MS_RST;
      gap_ms_r      <= GAP_MS_RST;
      pause_ms_r    <= PAUSE_MS_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_BLUE_COUNT:  blue_count_r  <= cfg_data[CNT_W-1:0];
        REG_GREEN_COUNT: green_count_r <= cfg_data[CNT_W-1:0];
        REG_ON_MS:       on_ms_r       <= cfg_data[MS_W-1:0];
        REG_OFF_MS:      off_ms_r      <= cfg_data[MS_W-1:0];
        REG_GAP_MS:      gap_ms_r      <= cfg_data[MS_W-1:0];
        REG_PAUSE_MS:    pause_ms_r    <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '{step: ST_BLUE_ON, blink: '0, tcnt: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) seq_r <= seq_nxt;
      if (in_xfer) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      blue_lit_r  <= (seq_nxt.step == ST_BLUE_ON);
      green_lit_r <= (seq_nxt.step == ST_GREEN_ON);
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue_lit  = blue_lit_r;
  assign out_green_lit = green_lit_r;
  assign out_phase     = phase_r;

  // A lit blue LED always matches the reported blue phase, with green dark
  a_lit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && blue_lit_r |-> phase_r == PH_BLUE && !green_lit_r)
    else $error("blue lit outside blue phase");

  // No tick, no time: the timer holds or is cleared by a run skip
  a_no_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tick |=> seq_r.tcnt == $past(seq_r.tcnt) || seq_r.tcnt == '0)
    else $error("timer moved without tick");

  // Blink index is cleared in the gap and pause steps
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.step == ST_GAP || seq_r.step == ST_PAUSE |-> seq_r.blink == '0)
    else $error("blink index nonzero outside a run");

endmodule

// ===== sim/tb_led_blink_code_sequencer.sv =====
// Self-checking testbench for the LED blink-code sequencer: directed table, then random frames.
`timescale 1ns / 1ps

module tb_led_blink_code_sequencer;
  import lbcs_pkg::*;

  // Watchdog: cycles with no transfer on any channel before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;
  // Random part: segments, each with its own register setting and idle mode.
  localparam int SEGMENTS = 16;
  localparam int SEG_ITEMS = 118;
  // Indexes past the register map; writes there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_VOID_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VOID_HI = 3'd7;

  // LED state and phase carried by one result transfer.
  typedef struct packed {
    logic               blue;
    logic               green;
    logic [PHASE_W-1:0] phase;
  } lamp_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item (optionally with a hand-typed result)
  // or a register write.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  tick;
    bit                    typed;
    lamp_t                 want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_blue_lit;
  logic                  out_green_lit;
  logic [PHASE_W-1:0]    out_phase;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Hand-typed expectation that travels with the item on the input channel.
  bit    drv_typed;
  lamp_t drv_want;

  int send_pct;
  int stall_pct;
  int mismatch_cnt;
  int quiet_cycles;

  lamp_t     lamp_q[$];
  plan_row_t plan_q[$];

  // Shadow of the block: registers and sequencer state.
  logic [CNT_W-1:0]          cnt_blue, cnt_green;
  logic [MS_W-1:0]           dur_on, dur_off, dur_gap, dur_pause;
  logic [STEP_W-1:0]         seq_step;
  logic [TIME_WIDTH_DEF-1:0] seq_time;
  logic [CNT_W-1:0]          seq_blink;

  led_blink_code_sequencer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tick      (in_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue_lit (out_blue_lit),
    .out_green_lit(out_green_lit),
    .out_phase    (out_phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Duration of the current step; a zero register counts as one millisecond.
  // Time counter and duration share a width, so no saturation is needed here.
  function automatic logic [MS_W-1:0] step_len();
    logic [MS_W-1:0] d;
    case (seq_step)
      ST_BLUE_ON, ST_GREEN_ON:   d = dur_on;
      ST_BLUE_OFF, ST_GREEN_OFF: d = dur_off;
      ST_GAP:                    d = dur_gap;
      default:                   d = dur_pause;
    endcase
    if (d == '0) d = MS_W'(1);
    return d;
  endfunction

  function automatic void enter_step(logic [STEP_W-1:0] s, logic [CNT_W-1:0] blink);
    seq_step  = s;
    seq_time  = '0;
    seq_blink = blink;
  endfunction

  // An "on" step with its count already used up is left at no cost in time.
  function automatic void skip_empty();
    if (seq_step == ST_BLUE_ON && seq_blink >= cnt_blue) enter_step(ST_GAP, '0);
    if (seq_step == ST_GREEN_ON && seq_blink >= cnt_green) enter_step(ST_PAUSE, '0);
  endfunction

  // Moves the shadow by one item and returns the lamps/phase it should report.
  function automatic lamp_t predict_lamps(logic tick);
    lamp_t r;
    int    nxt;
    skip_empty();
    if (tick) begin
      if (seq_time != '1) seq_time = seq_time + 1'b1;
      if (seq_time >= step_len()) begin
        nxt = int'(seq_blink) + 1;
        case (seq_step)
          ST_BLUE_ON:  enter_step(ST_BLUE_OFF, seq_blink);
          ST_BLUE_OFF: begin
            if (nxt < int'(cnt_blue)) enter_step(ST_BLUE_ON, nxt[CNT_W-1:0]);
            else enter_step(ST_GAP, '0);
          end
          ST_GAP:      enter_step(ST_GREEN_ON, '0);
          ST_GREEN_ON: enter_step(ST_GREEN_OFF, seq_blink);
          ST_GREEN_OFF: begin
            if (nxt < int'(cnt_green)) enter_step(ST_GREEN_ON, nxt[CNT_W-1:0]);
            else enter_step(ST_PAUSE, '0);
          end
          default:     enter_step(ST_BLUE_ON, '0);  // pause and unused codes
        endcase
      end
      skip_empty();
    end
    case (seq_step)
      ST_BLUE_ON, ST_BLUE_OFF:   r.phase = PH_BLUE;
      ST_GAP:                    r.phase = PH_GAP;
      ST_GREEN_ON, ST_GREEN_OFF: r.phase = PH_GREEN;
      default:                   r.phase = PH_PAUSE;
    endcase
    r.blue  = (seq_step == ST_BLUE_ON);
    r.green = (seq_step == ST_GREEN_ON);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor and result check
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string field, int exp_v, int act_v);
    mismatch_cnt++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endfunction

  // Result side is checked before the new item is queued: results are registered
  // at the input transfer, so one taken at this edge always belongs to an older item.
  always @(posedge clk) begin
    lamp_t seen, want, calc;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = {out_blue_lit, out_green_lit, out_phase};
        if (lamp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with none expected: blue %0b green %0b phase %0d",
                   $time, seen.blue, seen.green, seen.phase);
        end else begin
          want = lamp_q.pop_front();
          if (seen.blue !== want.blue) note_mismatch("blue_lit", want.blue, seen.blue);
          if (seen.green !== want.green) note_mismatch("green_lit", want.green, seen.green);
          if (seen.phase !== want.phase) note_mismatch("phase", want.phase, seen.phase);
        end
      end
      if (in_valid && !in_stall) begin
        calc = predict_lamps(in_tick);
        lamp_q.push_back(drv_typed ? drv_want : calc);
      end
    end
  end

  // Receiver back-pressure, random at the rate of the current segment.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, lamp_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Valid is left high after the transfer; the next call either idles or
  // replaces the payload, so valid never drops and rises within one step.
  task automatic send_item(logic tick, bit typed, lamp_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_tick   <= tick;
    drv_typed <= typed;
    drv_want  <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Drains the block before any register write: waits for an edge so the last item is
  // queued, then until every result is back, then a short settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write; the shadow copy is updated at the transfer edge.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLUE_COUNT:  cnt_blue  = data[CNT_W-1:0];
      REG_GREEN_COUNT: cnt_green = data[CNT_W-1:0];
      REG_ON_MS:       dur_on    = data;
      REG_OFF_MS:      dur_off   = data;
      REG_GAP_MS:      dur_gap   = data;
      REG_PAUSE_MS:    dur_pause = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Blink counts: mostly short runs, sometimes empty or full; the upper byte
  // is junk that the register must mask away.
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    logic [7:0] hi, lo;
    hi = 8'($urandom);
    case ($urandom_range(15))
      0:       lo = 8'd0;
      1:       lo = 8'hFF;
      2:       lo = 8'($urandom);
      default: lo = 8'($urandom_range(1, 4));
    endcase
    return {hi, lo};
  endfunction

  // Durations: mostly a few ms so frames turn over often; zero, full scale and
  // arbitrary values now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_ms();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(19))
      0:       v = '0;
      1:       v = '1;
      2:       v = CFG_DATA_W'($urandom);
      3:       v = CFG_DATA_W'($urandom_range(7, 40));
      default: v = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    return v;
  endfunction

  function automatic void row_item(logic tick, bit typed = 1'b0, lamp_t want = '0);
    plan_row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = '0;
    r.data  = '0;
    r.tick  = tick;
    r.typed = typed;
    r.want  = want;
    plan_q.push_back(r);
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    r.tick  = 1'b0;
    r.typed = 1'b0;
    r.want  = '0;
    plan_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int mode;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_tick   <= 1'b0;
    drv_typed <= 1'b0;
    drv_want  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    send_pct     = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;

    // Reset values of the shadow.
    cnt_blue  = '0;
    cnt_green = '0;
    dur_on    = ON_MS_RST;
    dur_off   = OFF_MS_RST;
    dur_gap   = GAP_MS_RST;
    dur_pause = PAUSE_MS_RST;
    enter_step(ST_BLUE_ON, '0);

    // Directed table.
    // Out of reset both counts are zero: the empty blue run drops straight into
    // the gap, even on an item that carries no tick, and 800 ms of gap holds.
    row_item(1'b0, 1'b1, '{blue: 1'b0, green: 1'b0, phase: PH_GAP});
    row_item(1'b1, 1'b1, '{blue: 1'b0, green: 1'b0, phase: PH_GAP});
    // Short frame: counts written with junk above bit 7, on time of zero
    // (treated as 1 ms), then writes to both unmapped indexes.
    row_cfg(REG_BLUE_COUNT, 16'h0302);
    row_cfg(REG_GREEN_COUNT, 16'hFF01);
    row_cfg(REG_ON_MS, 16'h0000);
    row_cfg(REG_OFF_MS, 16'h0001);
    row_cfg(REG_GAP_MS, 16'h0001);
    row_cfg(REG_PAUSE_MS, 16'h0001);
    row_cfg(REG_VOID_LO, 16'h0000);
    row_cfg(REG_VOID_HI, 16'hFFFF);
    // Walk gap -> green -> pause -> two blue blinks, with a held item inside.
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b0);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    // Full-scale durations and counts; time piles up in the current step.
    row_cfg(REG_ON_MS, 16'hFFFF);
    row_cfg(REG_OFF_MS, 16'hFFFF);
    row_cfg(REG_GAP_MS, 16'hFFFF);
    row_cfg(REG_PAUSE_MS, 16'hFFFF);
    row_cfg(REG_BLUE_COUNT, 16'h00FF);
    row_cfg(REG_GREEN_COUNT, 16'h00FF);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    // Durations cut below the time already spent: the step ends on the next tick.
    row_cfg(REG_ON_MS, 16'h0002);
    row_cfg(REG_OFF_MS, 16'h0002);
    row_cfg(REG_GAP_MS, 16'h0002);
    row_cfg(REG_PAUSE_MS, 16'h0002);
    row_item(1'b1);
    row_item(1'b1);
    row_item(1'b1);
    // Counts dropped to zero in mid-run: the run ends at the next item.
    row_cfg(REG_BLUE_COUNT, 16'h0000);
    row_cfg(REG_GREEN_COUNT, 16'h0000);
    row_item(1'b0);
    row_item(1'b1);
    row_item(1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_item(plan_q[i].tick, plan_q[i].typed, plan_q[i].want, 0);
      end
    end

    // Random part: each segment reprograms every register while idle (so the
    // sequencer is caught mid-step with new limits), then runs items under one
    // of four idle modes: none, sender 68%, receiver 68%, both 6%.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      cfg_write(REG_BLUE_COUNT, pick_count());
      cfg_write(REG_GREEN_COUNT, pick_count());
      cfg_write(REG_ON_MS, pick_ms());
      cfg_write(REG_OFF_MS, pick_ms());
      cfg_write(REG_GAP_MS, pick_ms());
      cfg_write(REG_PAUSE_MS, pick_ms());
      if ($urandom_range(2) == 0)
        cfg_write($urandom_range(1) ? REG_VOID_HI : REG_VOID_LO, CFG_DATA_W'($urandom));
      mode = seg % 4;
      send_pct  = (mode == 1) ? 68 : (mode == 3) ? 6 : 0;
      stall_pct = (mode == 2) ? 68 : (mode == 3) ? 6 : 0;
      // Ticks dominate so time actually moves; held items keep showing up.
      repeat (SEG_ITEMS) send_item($urandom_range(9) != 0, 1'b0, '0, send_pct);
    end

    wait_idle();
    stall_pct = 0;
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
